// ----- rtl/xct_pkg.sv -----
// Package for the XML byte tokenizer: result and queue types, lexer codes
// and the per-byte scan function. No dependencies.
`default_nettype none

package xct_pkg;

  localparam logic [1:0] MODE_MARKUP = 2'd0;
  localparam logic [1:0] MODE_TEXT   = 2'd1;
  localparam logic [1:0] MODE_QUOTED = 2'd2;
  localparam logic [1:0] MODE_WORD   = 2'd3;

  localparam logic [2:0] TT_OPEN   = 3'd0;
  localparam logic [2:0] TT_CLOSE  = 3'd1;
  localparam logic [2:0] TT_EQUALS = 3'd2;
  localparam logic [2:0] TT_STRING = 3'd3;
  localparam logic [2:0] TT_TEXT   = 3'd4;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_END    = 1'b1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic [1:0] mode;
    logic       esc;
    logic       has;
  } lex_state_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] token_type;
    logic [7:0] ch;
  } result_t;

  typedef struct packed {
    lex_state_t st;
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
    logic       again;
  } scan_out_t;

  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } q_entry_t;

  function automatic scan_out_t push_res(scan_out_t o, result_t r);
    scan_out_t t;
    t = o;
    if (o.cnt == 2'd0) begin
      t.r0  = r;
      t.cnt = 2'd1;
    end else if (o.cnt == 2'd1) begin
      t.r1  = r;
      t.cnt = 2'd2;
    end
    return t;
  endfunction

  function automatic scan_out_t end_tok(scan_out_t o, logic [2:0] tt, logic [7:0] ch);
    scan_out_t t;
    t        = push_res(o, '{kind: KIND_END, token_type: tt, ch: ch});
    t.st.has = 1'b0;
    t.st.esc = 1'b0;
    return t;
  endfunction

  function automatic scan_out_t append_byte(scan_out_t o, logic [7:0] c);
    scan_out_t t;
    t = o;
    if (o.st.has || c > CH_SPACE) begin
      t.st.esc = 1'b0;
      if (c == CH_LF) begin
        t = push_res(t, '{kind: KIND_APPEND, token_type: TT_OPEN, ch: CH_BSL});
        t = push_res(t, '{kind: KIND_APPEND, token_type: TT_OPEN, ch: CH_N});
      end else if (c == CH_CR) begin
        t = push_res(t, '{kind: KIND_APPEND, token_type: TT_OPEN, ch: CH_BSL});
        t = push_res(t, '{kind: KIND_APPEND, token_type: TT_OPEN, ch: CH_R});
      end else begin
        t = push_res(t, '{kind: KIND_APPEND, token_type: TT_OPEN, ch: c});
      end
      t.st.has = 1'b1;
    end
    return t;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB);
  endfunction

  function automatic scan_out_t scan_pass(scan_out_t o, logic [7:0] c);
    scan_out_t t;
    t       = o;
    t.again = 1'b0;
    case (o.st.mode)
      MODE_MARKUP: begin
        if (c == CH_LT) begin
          t = end_tok(t, TT_OPEN, c);
        end else if (c == CH_GT) begin
          t         = end_tok(t, TT_CLOSE, c);
          t.st.mode = MODE_TEXT;
        end else if (c == CH_EQ) begin
          t = end_tok(t, TT_EQUALS, c);
        end else if (c == CH_QUOTE) begin
          t.st.mode = MODE_QUOTED;
        end else if (!is_blank(c)) begin
          t.st.mode = MODE_WORD;
          t.again   = 1'b1;
        end
      end
      MODE_TEXT: begin
        if (c == CH_LT) begin
          t.st.mode = MODE_MARKUP;
          if (o.st.has) begin
            t = end_tok(t, TT_TEXT, CH_NUL);
          end
          t.again = 1'b1;
        end else begin
          t = append_byte(t, c);
        end
      end
      MODE_QUOTED: begin
        if (c == CH_QUOTE && !o.st.esc) begin
          t         = end_tok(t, TT_STRING, CH_NUL);
          t.st.mode = MODE_MARKUP;
        end else if (c == CH_BSL && !o.st.esc) begin
          t.st.esc = 1'b1;
        end else begin
          t = append_byte(t, c);
        end
      end
      default: begin
        if (c == CH_LT || c == CH_GT || c == CH_EQ || c == CH_QUOTE) begin
          t         = end_tok(t, TT_STRING, CH_NUL);
          t.st.mode = MODE_MARKUP;
          t.again   = 1'b1;
        end else if (c == CH_SPACE) begin
          t         = end_tok(t, TT_STRING, CH_NUL);
          t.st.mode = MODE_MARKUP;
        end else begin
          t = append_byte(t, c);
        end
      end
    endcase
    return t;
  endfunction

  // a rescanned byte never asks for a third pass
  function automatic scan_out_t scan_byte(lex_state_t s, logic [7:0] c);
    scan_out_t o0;
    scan_out_t o1;
    scan_out_t o2;
    o0       = '0;
    o0.st    = s;
    o1       = scan_pass(o0, c);
    o2       = scan_pass(o1, c);
    return o1.again ? o2 : o1;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/xct_front.sv -----
// Front end of the XML byte tokenizer: accepts bytes, holds the lexer state
// and builds one queue entry of up to two results per byte. Uses xct_pkg.
`default_nettype none

module xct_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [7:0]        in_char,
  output logic                   in_stall,
  input  wire logic              q_full,
  output logic                   q_push,
  output xct_pkg::q_entry_t      q_data
);
  import xct_pkg::*;

  lex_state_t st_r;
  lex_state_t st_nxt;
  scan_out_t  scan;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign scan     = scan_byte(st_r, in_char);

  assign q_push     = accept && (scan.cnt != 2'd0);
  assign q_data.two = (scan.cnt == 2'd2);
  assign q_data.r0  = scan.r0;
  assign q_data.r1  = scan.r1;

  always_comb begin
    st_nxt = st_r;
    if (accept) begin
      st_nxt = scan.st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{mode: MODE_MARKUP, esc: 1'b0, has: 1'b0};
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/xct_queue.sv -----
// Short queue of result entries between the front and back ends of the
// XML byte tokenizer. Uses xct_pkg.
`default_nettype none

module xct_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire xct_pkg::q_entry_t push_data,
  input  wire logic              pop,
  output xct_pkg::q_entry_t      head,
  output logic                   empty,
  output logic                   full
);
  import xct_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

  q_entry_t      mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_ptr_nxt;
  logic [AW:0]   cnt_r;
  logic [AW:0]   cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == FULL_CNT);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/xct_back.sv -----
// Back end of the XML byte tokenizer: unpacks queue entries into single
// results held in the output register. Uses xct_pkg.
`default_nettype none

module xct_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire xct_pkg::q_entry_t q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_kind,
  output logic [2:0]             out_token_type,
  output logic [7:0]             out_char,
  output logic                   out_last
);
  import xct_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  logic    sel_r;
  logic    sel_nxt;
  result_t res_r;
  logic    last_r;
  logic    load;
  logic    take;
  logic    is_last;
  result_t cur;

  assign load    = !valid_r || !out_stall;
  assign take    = load && !q_empty;
  assign is_last = sel_r || !q_head.two;
  assign cur     = sel_r ? q_head.r1 : q_head.r0;
  assign q_pop   = take && is_last;

  always_comb begin
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    if (load) begin
      valid_nxt = !q_empty;
    end
    if (take) begin
      sel_nxt = !is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r  <= cur;
      last_r <= is_last;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = res_r.kind;
  assign out_token_type = res_r.token_type;
  assign out_char       = res_r.ch;
  assign out_last       = last_r;

endmodule

`default_nettype wire

// ----- rtl/xml_char_tokenizer_top.sv -----
// Top level of the XML byte tokenizer: front end, result queue and back end.
// Uses xct_pkg, xct_front, xct_queue and xct_back.
//
// Usage:
//   Input channel: in_valid / in_stall carry one XML byte (in_char) per
//   transaction. Output channel: out_valid / out_stall carry one result per
//   transaction: out_kind (append or token end), out_token_type, out_char and
//   out_last, which marks the final result caused by an input byte. A byte
//   causes zero, one or two results; bytes with none give no transaction.
//   The results of a taken byte are written to the queue at the accepting
//   edge and then loaded into the output register, which drives the output
//   ports. Throughput: one byte per cycle while each gives at most one
//   result and the receiver does not stall; a byte with two results passes
//   the output register one result at a time, and the queue of QUEUE_DEPTH
//   entries absorbs such bursts.
//   in_stall rises only when the queue is full, which happens when the
//   receiver stalls for long enough or two-result bytes arrive back to back.
//   A stalled result holds on the output ports.
//   Reset: the lexer returns to between-markup with no token data and no
//   escape pending; queue and output register empty. A partial token at the
//   end of the stream is never finished.
`default_nettype none

module xml_char_tokenizer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_kind,
  output logic [2:0]      out_token_type,
  output logic [7:0]      out_char,
  output logic            out_last
);
  import xct_pkg::*;

  q_entry_t q_wdata;
  q_entry_t q_head;
  logic     q_push;
  logic     q_pop;
  logic     q_empty;
  logic     q_full;

  xct_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_char  (in_char),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  xct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  xct_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_token_type (out_token_type),
    .out_char       (out_char),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

// ----- rtl/xct_checker.sv -----
// Port checker for the XML byte tokenizer and its bind to the top level.
// Uses xct_pkg.
`default_nettype none

module xct_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_char,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_kind,
  input wire logic [2:0] out_token_type,
  input wire logic [7:0] out_char,
  input wire logic       out_last
);
  import xct_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_char))
    else $error("input transaction changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind)
      && $stable(out_token_type) && $stable(out_char) && $stable(out_last))
    else $error("output transaction changed while stalled");

  a_append_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_APPEND) |-> (out_token_type == TT_OPEN))
    else $error("append carries a token type");

  a_end_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_END) |-> (out_token_type <= TT_TEXT))
    else $error("token end with unknown type");

  a_no_raw_break: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_APPEND) |-> (out_char != CH_LF) && (out_char != CH_CR))
    else $error("line break appended unescaped");

endmodule

bind xml_char_tokenizer_top xct_checker u_xct_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_char        (in_char),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_token_type (out_token_type),
  .out_char       (out_char),
  .out_last       (out_last)
);

`default_nettype wire
